// File: rtl/core/wfr_pkg.sv
// ----------------------------------------------------------------------------
// wfr_pkg
// Types and codes shared by the waiter queue with removal.
// ----------------------------------------------------------------------------
`default_nettype none

package wfr_pkg;

    localparam int ID_W        = 4;
    localparam int CNT_W       = 5;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int ENTRIES_DEF = 16;
    // ids carry four bits, so no more than this many can ever be queued
    localparam int ID_SPACE    = 1 << ID_W;

    localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_QUEUED  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   entry_id;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     entry_out;
        logic [CNT_W-1:0]    count_now;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/waiter_fifo_with_removal_top.sv
// ----------------------------------------------------------------------------
// waiter_fifo_with_removal_top
// Queue of waiter ids held as a singly linked list in a small link memory,
// with an active mark per id, supporting push, pop and removal by id.
// ----------------------------------------------------------------------------
//  channel   ports                          transaction
//  command   i_start, o_busy, i_cmd         at edge with i_start && !o_busy
//  result    o_valid, o_result              one cycle, o_valid high
//
//  push and refused commands are answered from the execute state, pop from the
//  pop state after it, remove from the walk state on reaching the id; the walk
//  reads one link per cycle through the single registered link memory port.
//  o_busy is high from the accepting edge until the result is shown, and a
//  new command may be accepted while a result is on the ports.
//  synchronous active-low reset empties the queue; no clearing pass is needed.
//  the receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module waiter_fifo_with_removal_top #(
    parameter int ENTRIES = wfr_pkg::ENTRIES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire wfr_pkg::t_cmd    i_cmd,
    output logic                  o_busy,
    output logic                  o_valid,
    output wfr_pkg::t_result      o_result
);
    import wfr_pkg::*;

    localparam int DEPTH   = (ENTRIES < ID_SPACE) ? ENTRIES : ID_SPACE;
    localparam int DEPTH_W = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_POP  = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;

    logic [ID_W-1:0] r_link [DEPTH];
    logic [ID_W-1:0] r_rd_data;

    logic [2:0]       r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [DEPTH-1:0] r_active, n_active;
    logic [ID_W-1:0]  r_head, n_head;
    logic [ID_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [ID_W-1:0]  r_cur, n_cur;
    logic [ID_W-1:0]  r_prev, n_prev;
    logic             r_have_prev, n_have_prev;
    logic [CNT_W-1:0] r_steps, n_steps;
    logic             r_valid, n_valid;
    t_result          r_result, n_result;

    logic               rd_en;
    logic [DEPTH_W-1:0] rd_addr;
    logic               wr_en;
    logic [DEPTH_W-1:0] wr_addr;
    logic [ID_W-1:0]    wr_data;

    function automatic logic id_ok(input logic [ID_W-1:0] id);
        return 32'(id) < ENTRIES;
    endfunction

    function automatic logic [DEPTH_W-1:0] to_idx(input logic [ID_W-1:0] id);
        return id[DEPTH_W-1:0];
    endfunction

    logic [CNT_W-1:0] count_dec;
    assign count_dec = (r_count != '0) ? r_count - CNT_W'(1) : '0;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_active    = r_active;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_steps     = r_steps;
        n_valid     = 1'b0;
        n_result    = r_result;
        rd_en       = 1'b0;
        rd_addr     = to_idx(r_head);
        wr_en       = 1'b0;
        wr_addr     = to_idx(r_tail);
        wr_data     = r_cmd.entry_id;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state  = S_IDLE;
                n_valid  = 1'b1;
                n_result = '{status: STATUS_MISSING, entry_out: '0, count_now: r_count};
                unique case (r_cmd.mode)
                    MODE_PUSH: begin
                        if (!id_ok(r_cmd.entry_id)) begin
                            n_result.status = STATUS_MISSING;
                        end else if (r_active[to_idx(r_cmd.entry_id)]) begin
                            n_result.status = STATUS_QUEUED;
                        end else begin
                            // link the old tail only when the queue holds something
                            wr_en = (r_count != '0);
                            if (r_count == '0) begin
                                n_head = r_cmd.entry_id;
                            end
                            n_tail = r_cmd.entry_id;
                            n_active[to_idx(r_cmd.entry_id)] = 1'b1;
                            n_count = r_count + CNT_W'(1);
                            n_result = '{status: STATUS_DONE, entry_out: r_cmd.entry_id,
                                         count_now: r_count + CNT_W'(1)};
                        end
                    end
                    MODE_POP: begin
                        if (r_count != '0 && id_ok(r_head)) begin
                            rd_en   = 1'b1;
                            n_cur   = r_head;
                            n_valid = 1'b0;
                            n_state = S_POP;
                        end
                    end
                    MODE_REMOVE: begin
                        if (id_ok(r_cmd.entry_id) && r_active[to_idx(r_cmd.entry_id)]
                                && r_count != '0) begin
                            rd_en       = 1'b1;
                            n_cur       = r_head;
                            n_have_prev = 1'b0;
                            n_steps     = '0;
                            n_valid     = 1'b0;
                            n_state     = S_WALK;
                        end
                    end
                    default: begin
                        n_result.status = STATUS_MISSING;
                    end
                endcase
            end
            S_POP: begin
                n_head = r_rd_data;
                n_active[to_idx(r_cur)] = 1'b0;
                n_count = count_dec;
                if (count_dec == '0) begin
                    n_head = '0;
                    n_tail = '0;
                end
                n_valid  = 1'b1;
                n_result = '{status: STATUS_DONE, entry_out: r_cur, count_now: count_dec};
                n_state  = S_IDLE;
            end
            S_WALK: begin
                // r_rd_data holds the link of r_cur
                if (!id_ok(r_cur)) begin
                    n_valid  = 1'b1;
                    n_result = '{status: STATUS_MISSING, entry_out: '0, count_now: r_count};
                    n_state  = S_IDLE;
                end else if (r_cur == r_cmd.entry_id) begin
                    if (!r_have_prev) begin
                        n_head = r_rd_data;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = to_idx(r_prev);
                        wr_data = r_rd_data;
                    end
                    if (r_tail == r_cmd.entry_id) begin
                        n_tail = r_have_prev ? r_prev : '0;
                    end
                    n_active[to_idx(r_cur)] = 1'b0;
                    n_count = count_dec;
                    if (count_dec == '0) begin
                        n_head = '0;
                        n_tail = '0;
                    end
                    n_valid  = 1'b1;
                    n_result = '{status: STATUS_DONE, entry_out: r_cur, count_now: count_dec};
                    n_state  = S_IDLE;
                end else if (r_steps + CNT_W'(1) >= r_count) begin
                    n_valid  = 1'b1;
                    n_result = '{status: STATUS_MISSING, entry_out: '0, count_now: r_count};
                    n_state  = S_IDLE;
                end else begin
                    n_prev      = r_cur;
                    n_have_prev = 1'b1;
                    n_cur       = r_rd_data;
                    n_steps     = r_steps + CNT_W'(1);
                    rd_en       = 1'b1;
                    rd_addr     = to_idx(r_rd_data);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (r_state == S_EXEC || r_state == S_IDLE) begin
            if (r_state == S_EXEC && (r_cmd.mode == MODE_POP || r_cmd.mode == MODE_REMOVE)) begin
                rd_addr = to_idx(r_head);
            end
        end
    end

    // link memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_link[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_link[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_have_prev <= n_have_prev;
        r_steps     <= n_steps;
        r_result    <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: rtl/core/wfr_checker.sv
// ----------------------------------------------------------------------------
// wfr_checker
// Port-level checks on the waiter queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wfr_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_start,
    input wire wfr_pkg::t_cmd    i_cmd,
    input wire logic             o_busy,
    input wire logic             o_valid,
    input wire wfr_pkg::t_result o_result
);
    import wfr_pkg::*;

    logic accept;
    assign accept = i_start && !o_busy;

    // a result is shown only once the sequencer is free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result shown while busy");

    // a push is always answered from the execute state, with no pop or walk state between
    a_push_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.mode == MODE_PUSH) |-> ##2 o_valid)
        else $error("push result late or missing");

    // results never come back to back
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back results");

    // refusals carry no id and counts stay in range
    a_result_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_result.status == STATUS_DONE || o_result.entry_out == '0)
                     && o_result.count_now <= CNT_W'(ID_SPACE)))
        else $error("malformed result");

endmodule

bind waiter_fifo_with_removal_top wfr_checker u_wfr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_cmd    (i_cmd),
    .o_busy   (o_busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire

// File: sim/wfr_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wfr_result_checker
// Watches the command and result channels of the waiter queue, keeps its own
// linked-list queue of waiter ids, and compares each result with the oldest
// predicted one. Counts failures for the testbench top.
// ----------------------------------------------------------------------------

module wfr_result_checker
    import wfr_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_busy,
    input  wire t_cmd    i_cmd,
    input  wire logic    i_valid,
    input  wire t_result i_result,
    output int           o_fail_count,
    output int           o_outstanding
);

    logic [ID_W-1:0]    link_mem [ENTRIES];
    logic [ENTRIES-1:0] queued;
    logic [ID_W-1:0]    head_id;
    logic [ID_W-1:0]    tail_id;
    logic [CNT_W-1:0]   depth;

    t_result awaited_results [$];
    int      fails;

    initial begin
        fails = 0;
    end

    task automatic clear_queue_model();
        for (int i = 0; i < ENTRIES; i++) begin
            link_mem[i] = '0;
        end
        queued  = '0;
        head_id = '0;
        tail_id = '0;
        depth   = '0;
    endtask

    task automatic drop_waiter();
        if (depth != 0) begin
            depth = depth - CNT_W'(1);
        end
        if (depth == 0) begin
            head_id = '0;
            tail_id = '0;
        end
    endtask

    task automatic apply_waiter_op(input t_cmd cmd, output t_result res);
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] cur;
        logic [ID_W-1:0] prev;
        bit              have_prev;
        bit              found;
        bit              id_ok;
        int              step;
        id        = cmd.entry_id;
        id_ok     = (32'(id) < ENTRIES);
        prev      = '0;
        have_prev = 1'b0;
        found     = 1'b0;
        res.status    = STATUS_MISSING;
        res.entry_out = '0;
        case (cmd.mode)
            MODE_PUSH: begin
                if (!id_ok) begin
                    res.status = STATUS_MISSING;
                end else if (queued[id]) begin
                    res.status = STATUS_QUEUED;
                end else begin
                    link_mem[id] = '0;
                    queued[id]   = 1'b1;
                    if (depth == 0) begin
                        head_id = id;
                    end else begin
                        link_mem[tail_id] = id;
                    end
                    tail_id       = id;
                    depth         = depth + CNT_W'(1);
                    res.status    = STATUS_DONE;
                    res.entry_out = id;
                end
            end
            MODE_POP: begin
                if (depth != 0) begin
                    cur           = head_id;
                    head_id       = link_mem[cur];
                    link_mem[cur] = '0;
                    queued[cur]   = 1'b0;
                    drop_waiter();
                    res.status    = STATUS_DONE;
                    res.entry_out = cur;
                end
            end
            MODE_REMOVE: begin
                if (id_ok && queued[id] && depth != 0) begin
                    cur = head_id;
                    for (step = 0; step < int'(depth) && !found; step++) begin
                        if (cur == id) begin
                            found = 1'b1;
                            if (!have_prev) begin
                                head_id = link_mem[id];
                            end else begin
                                link_mem[prev] = link_mem[id];
                            end
                            // removing the tail hands it back to the predecessor
                            if (tail_id == id) begin
                                tail_id = have_prev ? prev : '0;
                            end
                            link_mem[id] = '0;
                            queued[id]   = 1'b0;
                            drop_waiter();
                            res.status    = STATUS_DONE;
                            res.entry_out = id;
                        end else begin
                            prev      = cur;
                            have_prev = 1'b1;
                            cur       = link_mem[cur];
                        end
                    end
                end
            end
            default: begin
                res.status = STATUS_MISSING;
            end
        endcase
        res.count_now = depth;
    endtask

    always @(posedge i_clk) begin
        t_result exp_res;
        t_result next_res;
        if (!i_rst_n) begin
            clear_queue_model();
            awaited_results.delete();
        end else begin
            // results belong to earlier transactions, so compare before predicting
            if (i_valid) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no transaction: status %0d entry_out %0d count_now %0d",
                           i_result.status, i_result.entry_out, i_result.count_now);
                    fails++;
                end else begin
                    exp_res = awaited_results.pop_front();
                    if (i_result.status !== exp_res.status) begin
                        $error("status: expected %0d, actual %0d",
                               exp_res.status, i_result.status);
                        fails++;
                    end
                    if (i_result.entry_out !== exp_res.entry_out) begin
                        $error("entry_out: expected %0d, actual %0d",
                               exp_res.entry_out, i_result.entry_out);
                        fails++;
                    end
                    if (i_result.count_now !== exp_res.count_now) begin
                        $error("count_now: expected %0d, actual %0d",
                               exp_res.count_now, i_result.count_now);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                apply_waiter_op(i_cmd, next_res);
                awaited_results.push_back(next_res);
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= awaited_results.size();
    end

endmodule

// File: sim/waiter_fifo_with_removal_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// waiter_fifo_with_removal_top_tb
// Drives push, pop and remove commands into the waiter queue: a directed
// opening over the corner cases, then phases of random commands biased to
// fill, drain or churn the list, random gaps in most phases, and a checker.
// ----------------------------------------------------------------------------

module waiter_fifo_with_removal_top_tb;

    import wfr_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam int PHASE_ITEMS = 48;
    localparam int PHASES      = 30;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 40;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    t_cmd    cmd   = '0;
    logic    busy;
    logic    valid;
    t_result result;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    bit gaps_on     = 1'b1;

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    waiter_fifo_with_removal_top dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_start  (start),
        .i_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (valid),
        .o_result (result)
    );

    wfr_result_checker result_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_cmd         (cmd),
        .i_valid       (valid),
        .i_result      (result),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // an idle cycle, with junk on the command bus
    task automatic idle_cycle();
        @(negedge clk);
        start <= 1'b0;
        cmd   <= t_cmd'($urandom);
        @(posedge clk);
    endtask

    // returns just after the edge that takes the transaction; start stays high
    task automatic issue(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id);
        logic busy_seen;
        while (gaps_on && $urandom_range(0, 99) < 32) begin
            idle_cycle();
        end
        @(negedge clk);
        start <= 1'b1;
        cmd   <= '{mode: mode, entry_id: id};
        busy_seen = busy;
        @(posedge clk);
        while (busy_seen) begin
            @(negedge clk);
            busy_seen = busy;
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0) begin
            @(negedge clk);
        end
    endtask

    function automatic logic [MODE_W-1:0] pick_mode(input int push_pct, input int pop_pct,
                                                     input int remove_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
            return MODE_PUSH;
        end else if (roll < push_pct + pop_pct) begin
            return MODE_POP;
        end else if (roll < push_pct + pop_pct + remove_pct) begin
            return MODE_REMOVE;
        end
        return MODE_NONE;
    endfunction

    initial begin
        int push_pct;
        int pop_pct;
        int remove_pct;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening
        issue(MODE_POP,    4'd0);
        issue(MODE_REMOVE, 4'd5);
        issue(MODE_NONE,   4'd0);
        issue(MODE_PUSH,   4'd0);
        issue(MODE_PUSH,   4'd15);
        issue(MODE_PUSH,   4'd0);
        issue(MODE_PUSH,   4'd7);
        issue(MODE_PUSH,   4'd9);
        issue(MODE_REMOVE, 4'd15);
        issue(MODE_REMOVE, 4'd9);
        issue(MODE_REMOVE, 4'd0);
        issue(MODE_REMOVE, 4'd0);
        issue(MODE_POP,    4'd0);
        issue(MODE_PUSH,   4'd15);
        issue(MODE_POP,    4'd10);
        issue(MODE_POP,    4'd0);
        issue(MODE_NONE,   4'd15);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            gaps_on = !(p >= 8 && p < 12);
            case (p % 4)
                0: begin push_pct = 75; pop_pct = 10; remove_pct = 12; end
                1: begin push_pct = 20; pop_pct = 20; remove_pct = 57; end
                2: begin push_pct = 40; pop_pct = 30; remove_pct = 27; end
                default: begin push_pct = 10; pop_pct = 60; remove_pct = 27; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                issue(pick_mode(push_pct, pop_pct, remove_pct), ID_W'($urandom_range(0, 15)));
            end
            if (p % 5 == 4) begin
                drain_results();
            end
        end
        gaps_on = 1'b1;

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0) begin
            $display("waiter_fifo_with_removal_top: match");
        end else begin
            $display("waiter_fifo_with_removal_top: mismatch");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
        end
        $display("waiter_fifo_with_removal_top: mismatch");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/wfr_pkg.sv
rtl/core/waiter_fifo_with_removal_top.sv
rtl/core/wfr_checker.sv
sim/wfr_result_checker.sv
sim/waiter_fifo_with_removal_top_tb.sv
